@@ hw/rtl/stmin_pkg.sv @@
// Shared types, sizes and helpers for the sparse table range minimum engine.
// No dependencies; every other file depends on this package.
package stmin_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int LEVEL_COUNT  = 11;
	localparam int VALUE_BITS   = 32;

	localparam int IDX_BITS   = $clog2(MAX_ELEMENTS);
	localparam int CNT_BITS   = $clog2(MAX_ELEMENTS + 1);
	localparam int LVL_BITS   = $clog2(LEVEL_COUNT + 1);
	localparam int TABLE_SIZE = LEVEL_COUNT * MAX_ELEMENTS;
	localparam int ADDR_BITS  = $clog2(TABLE_SIZE);

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [ADDR_BITS-1:0]         addr_t;
	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;
	typedef logic [LVL_BITS-1:0]          lvl_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_BUILT = 2'd3
	} status_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Two read addresses presented to the table each cycle
	typedef struct packed {
		addr_t addr_a;
		addr_t addr_b;
	} tbl_rd_t;

	// One write into the table
	typedef struct packed {
		logic   en;
		addr_t  addr;
		value_t data;
	} tbl_wr_t;

	// Flat table address of entry idx on a level
	function automatic addr_t table_addr(input lvl_t level, input idx_t idx);
		table_addr = ADDR_BITS'(int'(level) * MAX_ELEMENTS + int'(idx));
	endfunction

	function automatic value_t min_value(input value_t a, input value_t b);
		min_value = (a < b) ? a : b;
	endfunction

endpackage

@@ hw/rtl/stmin_ifs.sv @@
// Valid/ready channels carrying request items and result items.
// Depends on stmin_pkg for payload types.
interface stmin_in_if;
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	stmin_pkg::value_t       value;
	logic                    last_value;
	logic [9:0]              range_start;
	logic [10:0]             range_end;

	modport source(output valid, opcode, value, last_value, range_start, range_end,
		input ready);
	modport sink(input valid, opcode, value, last_value, range_start, range_end,
		output ready);
endinterface

interface stmin_out_if;
	logic                    valid;
	logic                    ready;
	stmin_pkg::value_t       minimum;
	stmin_pkg::status_t      status;

	modport source(output valid, minimum, status, input ready);
	modport sink(input valid, minimum, status, output ready);
endinterface

@@ hw/rtl/sparse_table_range_minimum.sv @@
// Sparse table range minimum engine. A load request appends a signed value unless the
// array is full; the load marked last closes the array and starts the build, which
// fills each level k from level k-1 at one entry per cycle; no request is taken
// during the build. A query request reads two level entries through the registered
// read ports of the dual-read table memory and returns their minimum. Every
// request gives exactly one result; a result waiting in the output register
// holds off the next request. The table has no clearing pass after reset.
module sparse_table_range_minimum (
	input  logic        clk,
	input  logic        arst_n,
	stmin_in_if.sink    req,
	stmin_out_if.source rsp
);
	import stmin_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_QUERY, S_BUILD} state_t;

	state_t   state_q;
	cnt_t     count_q;
	logic     ready_tbl_q;
	logic     out_valid_q;
	value_t   out_min_q;
	status_t  out_status_q;
	status_t  qstatus_s1;

	logic     accept;
	logic     is_load;
	logic     out_fill;
	cnt_t     load_base;
	logic     full;
	cnt_t     count_next;
	cnt_t     start_ext;
	cnt_t     len;
	lvl_t     level;
	cnt_t     span;
	cnt_t     b_idx;
	status_t  qstatus;

	tbl_rd_t  q_rd;
	tbl_rd_t  b_rd;
	tbl_rd_t  t_rd;
	tbl_wr_t  b_wr;
	tbl_wr_t  t_wr;
	value_t   rdata_a;
	value_t   rdata_b;
	logic     b_start;
	logic     b_done;

	assign req.ready   = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept      = req.valid && req.ready;
	assign is_load     = (req.opcode == OP_LOAD);
	assign rsp.valid   = out_valid_q;
	assign rsp.minimum = out_min_q;
	assign rsp.status  = out_status_q;

	// A load or a finished query fills the result register
	assign out_fill    = (accept && is_load) || (state_q == S_QUERY);

	// Load bookkeeping: a load after a build restarts the array
	always_comb begin
		load_base  = ready_tbl_q ? '0 : count_q;
		full       = load_base >= cnt_t'(MAX_ELEMENTS);
		count_next = full ? load_base : load_base + cnt_t'(1);
	end

	// Query decode: level of the range length and both entry addresses
	always_comb begin
		start_ext = {1'b0, req.range_start};
		len       = req.range_end - start_ext;
		level     = '0;
		for (int i = 0; i < CNT_BITS; i++) begin
			if (len[i]) begin
				level = lvl_t'(i);
			end
		end
		span  = cnt_t'(1) << level;
		b_idx = req.range_end - span;
		priority if (!ready_tbl_q) begin
			qstatus = ST_NOT_BUILT;
		end else if (start_ext >= req.range_end || req.range_end > count_q) begin
			qstatus = ST_RANGE;
		end else if (level >= lvl_t'(LEVEL_COUNT)) begin
			qstatus = ST_RANGE;
		end else begin
			qstatus = ST_OK;
		end
		q_rd.addr_a = table_addr(level, req.range_start);
		q_rd.addr_b = table_addr(level, b_idx[IDX_BITS-1:0]);
	end

	// Share the table ports between requests and the builder
	always_comb begin
		t_rd = (state_q == S_BUILD) ? b_rd : q_rd;
		if (accept && is_load && !full) begin
			t_wr.en   = 1'b1;
			t_wr.addr = table_addr('0, load_base[IDX_BITS-1:0]);
			t_wr.data = req.value;
		end else begin
			t_wr = b_wr;
		end
	end

	assign b_start = accept && is_load && req.last_value;

	stmin_table u_table (
		.clk     (clk),
		.wr      (t_wr),
		.rd      (t_rd),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	stmin_builder u_builder (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (b_start),
		.start_count (count_next),
		.rdata_a     (rdata_a),
		.rdata_b     (rdata_b),
		.rd          (b_rd),
		.wr          (b_wr),
		.done        (b_done)
	);

	// Control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ready_tbl_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			qstatus_s1   <= ST_OK;
		end else begin
			out_valid_q <= out_fill || (out_valid_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_load) begin
							count_q      <= count_next;
							ready_tbl_q  <= 1'b0;
							out_status_q <= full ? ST_FULL : ST_OK;
							if (req.last_value) begin
								state_q <= S_BUILD;
							end
						end else begin
							qstatus_s1 <= qstatus;
							state_q    <= S_QUERY;
						end
					end
				end
				S_QUERY: begin
					out_status_q <= qstatus_s1;
					state_q      <= S_IDLE;
				end
				S_BUILD: begin
					if (b_done) begin
						ready_tbl_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result value: zero for loads and failed queries
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && is_load) begin
			out_min_q <= '0;
		end else if (state_q == S_QUERY) begin
			out_min_q <= (qstatus_s1 == ST_OK) ? min_value(rdata_a, rdata_b) : '0;
		end
	end

endmodule

@@ hw/rtl/stmin_table.sv @@
// Level table storage: one write port, two registered read ports.
// Depends on stmin_pkg.
module stmin_table (
	input  logic              clk,
	input  stmin_pkg::tbl_wr_t wr,
	input  stmin_pkg::tbl_rd_t rd,
	output stmin_pkg::value_t  rdata_a,
	output stmin_pkg::value_t  rdata_b
);
	import stmin_pkg::*;

	value_t mem [TABLE_SIZE];

	// Write at the requested entry
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read both ports through registered outputs
	always_ff @(posedge clk) begin
		rdata_a <= mem[rd.addr_a];
		rdata_b <= mem[rd.addr_b];
	end

endmodule

@@ hw/rtl/stmin_builder.sv @@
// Build sequencer: walks each level that fits the element count, reads two entries
// of the level below and writes their minimum in the next cycle. Depends on stmin_pkg.
module stmin_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  stmin_pkg::cnt_t    start_count,
	input  stmin_pkg::value_t  rdata_a,
	input  stmin_pkg::value_t  rdata_b,
	output stmin_pkg::tbl_rd_t rd,
	output stmin_pkg::tbl_wr_t wr,
	output logic               done
);
	import stmin_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_LEVEL, B_RUN} bstate_t;

	bstate_t           state_q;
	lvl_t              level_q;
	cnt_t              pos_q;
	cnt_t              count_q;
	logic              wr_valid_s1;
	addr_t             wr_addr_s1;
	logic              done_q;

	logic [CNT_BITS:0] span;
	logic [CNT_BITS:0] next_span;
	lvl_t              next_level;
	logic              fits;
	logic              more_levels;
	cnt_t              half_pos;
	lvl_t              src_level;

	// Level geometry
	always_comb begin
		span        = (CNT_BITS + 1)'(1) << level_q;
		next_level  = level_q + lvl_t'(1);
		next_span   = (CNT_BITS + 1)'(1) << next_level;
		fits        = ({1'b0, pos_q} + span) <= {1'b0, count_q};
		more_levels = (next_level < lvl_t'(LEVEL_COUNT)) && (next_span <= {1'b0, count_q});
		half_pos    = pos_q + span[CNT_BITS:1];
		src_level   = level_q - lvl_t'(1);
	end

	// Read the two source entries of the current position
	assign rd.addr_a = table_addr(src_level, pos_q[IDX_BITS-1:0]);
	assign rd.addr_b = table_addr(src_level, half_pos[IDX_BITS-1:0]);

	// Write back the minimum once the read data lands
	assign wr.en   = wr_valid_s1;
	assign wr.addr = wr_addr_s1;
	assign wr.data = min_value(rdata_a, rdata_b);

	assign done = done_q;

	// Sequence levels and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			level_q     <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			wr_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			wr_valid_s1 <= (state_q == B_RUN) && fits;
			done_q      <= (state_q == B_LEVEL) && !more_levels;
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						count_q <= start_count;
						level_q <= '0;
						state_q <= B_LEVEL;
					end
				end
				B_LEVEL: begin
					if (more_levels) begin
						level_q <= next_level;
						pos_q   <= '0;
						state_q <= B_RUN;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_RUN: begin
					// the cycle without a read drains the last write of the level
					if (fits) begin
						pos_q <= pos_q + cnt_t'(1);
					end else begin
						state_q <= B_LEVEL;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Destination of the pending write
	always_ff @(posedge clk) begin
		wr_addr_s1 <= table_addr(level_q, pos_q[IDX_BITS-1:0]);
	end

endmodule
